// File: hw/rtl/scs_pkg.sv
package scs_pkg;

    localparam int DEPTH = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ENTRY_W = 96;
    localparam int COUNT_OUT_W = 7;

    localparam logic [3:0] CMD_PUSH = 4'd0;
    localparam logic [3:0] CMD_POP = 4'd1;
    localparam logic [3:0] CMD_READ = 4'd2;
    localparam logic [3:0] CMD_CLEAR = 4'd3;
    localparam logic [3:0] CMD_FIND_HANDLE = 4'd4;
    localparam logic [3:0] CMD_FIND_CLASS = 4'd5;
    localparam logic [3:0] CMD_CLASS_TAG_EQ = 4'd6;
    localparam logic [3:0] CMD_CLASS_TAG_NE = 4'd7;
    localparam logic [3:0] CMD_FIND_TAG = 4'd8;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [3:0]  command;
        logic [31:0] handle;
        logic [31:0] class_key;
        logic [31:0] tag_key;
    } scs_in_t;

    typedef struct packed {
        logic [1:0]             status;
        logic                   found;
        logic [31:0]            top_handle;
        logic [31:0]            top_class;
        logic [31:0]            top_tag;
        logic [COUNT_OUT_W-1:0] entry_count;
    } scs_out_t;

    typedef struct packed {
        logic [31:0] handle;
        logic [31:0] class_id;
        logic [31:0] tag;
    } scs_entry_t;

endpackage

// File: hw/rtl/scs_ram.sv
module scs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: hw/rtl/searchable_control_stack.sv
// Push, clear and unknown commands, errors and a search of an empty stack go straight to S_OUT;
// pop and read first wait in S_RDWAIT for the registered RAM read, and a search runs in S_SEARCH.
// A search reads one entry per cycle through the RAM port into one shared comparator
// and stops early on a match. One transaction is in work at a time; s_ready returns
// in the same cycle as m_valid rises, and S_OUT waits while an earlier result is unaccepted.
// aresetn (synchronous, active low) empties the stack; entry storage is not cleared.
module searchable_control_stack (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  scs_pkg::scs_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output scs_pkg::scs_out_t m_data
);

    import scs_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDWAIT = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_OUT = 3'd3;

    logic [2:0] state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    scs_in_t cmd_reg, cmd_next;
    logic [1:0] status_reg, status_next;
    logic found_reg, found_next;
    scs_entry_t top_reg, top_next;
    logic m_valid_reg, m_valid_next;
    scs_out_t m_data_reg, m_data_next;

    logic ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    scs_entry_t ram_wdata;
    scs_entry_t ram_rdata;
    logic hit;
    logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

    scs_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    // Shared comparator: one stored entry against the search keys per cycle.
    always_comb begin
        unique case (cmd_reg.command)
            CMD_FIND_HANDLE: hit = ram_rdata.handle == cmd_reg.handle;
            CMD_FIND_CLASS: hit = ram_rdata.class_id == cmd_reg.class_key;
            CMD_CLASS_TAG_EQ: hit = ram_rdata.class_id == cmd_reg.class_key
                                    && ram_rdata.tag == cmd_reg.tag_key;
            CMD_CLASS_TAG_NE: hit = ram_rdata.class_id == cmd_reg.class_key
                                    && ram_rdata.tag != cmd_reg.tag_key;
            CMD_FIND_TAG: hit = ram_rdata.tag == cmd_reg.tag_key;
            default: hit = 1'b0;
        endcase
    end

    assign s_ready = state_reg == S_IDLE;
    assign count_ext = {{COUNT_OUT_W{1'b0}}, count_reg};

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        rd_idx_next = rd_idx_reg;
        cmd_next = cmd_reg;
        status_next = status_reg;
        found_next = found_reg;
        top_next = top_reg;
        m_valid_next = m_valid_reg;
        m_data_next = m_data_reg;
        ram_we = 1'b0;
        ram_waddr = count_reg[ADDR_W-1:0];
        ram_wdata.handle = s_data.handle;
        ram_wdata.class_id = s_data.class_key;
        ram_wdata.tag = s_data.tag_key;
        ram_raddr = rd_idx_reg[ADDR_W-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next = s_data;
                    status_next = ST_OK;
                    found_next = 1'b0;
                    top_next = '0;
                    state_next = S_OUT;
                    unique case (s_data.command)
                        CMD_PUSH: begin
                            if (count_reg == CNT_W'(DEPTH)) begin
                                status_next = ST_FULL;
                            end else begin
                                ram_we = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_POP, CMD_READ: begin
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                            end else begin
                                ram_raddr = ADDR_W'(count_reg - 1'b1);
                                state_next = S_RDWAIT;
                            end
                        end
                        CMD_CLEAR: begin
                            count_next = '0;
                        end
                        CMD_FIND_HANDLE, CMD_FIND_CLASS, CMD_CLASS_TAG_EQ,
                        CMD_CLASS_TAG_NE, CMD_FIND_TAG: begin
                            if (count_reg != '0) begin
                                ram_raddr = '0;
                                rd_idx_next = CNT_W'(1);
                                state_next = S_SEARCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RDWAIT: begin
                top_next = ram_rdata;
                if (cmd_reg.command == CMD_POP) begin
                    count_next = count_reg - 1'b1;
                end
                state_next = S_OUT;
            end
            S_SEARCH: begin
                // The read data belongs to the entry issued in the previous cycle.
                if (hit) begin
                    found_next = 1'b1;
                    state_next = S_OUT;
                end else if (rd_idx_reg == count_reg) begin
                    state_next = S_OUT;
                end else begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next.status = status_reg;
                    m_data_next.found = found_reg;
                    m_data_next.top_handle = top_reg.handle;
                    m_data_next.top_class = top_reg.class_id;
                    m_data_next.top_tag = top_reg.tag;
                    m_data_next.entry_count = count_ext[COUNT_OUT_W-1:0];
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rd_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            rd_idx_reg <= rd_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        status_reg <= status_next;
        found_reg <= found_next;
        top_reg <= top_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds stack depth");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.command == CMD_PUSH && count_reg != CNT_W'(DEPTH)
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push on a non-full stack did not add an entry");

    a_search_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SEARCH |-> rd_idx_reg != '0 && rd_idx_reg <= count_reg)
        else $error("search index outside stored entries");

    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.found |-> m_data.status == ST_OK)
        else $error("search hit reported with an error status");
`endif

endmodule
